>>> hdl/m2d_pkg.sv
package m2d_pkg;

	localparam int MAX_EXP_BITS  = 11;
	localparam int MAX_MANT_BITS = 52;
	localparam int CFG_W         = 6;

	localparam logic [CFG_W-1:0] REG_EXP_BITS  = 6'd0;
	localparam logic [CFG_W-1:0] REG_MANT_BITS = 6'd1;

	localparam logic [3:0] EXP_BITS_RESET  = 4'd8;
	localparam logic [5:0] MANT_BITS_RESET = 6'd23;

	localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;
	localparam logic [10:0] DBL_EMAX = 11'h7FF;
	localparam logic [11:0] DBL_BIAS = 12'd1023;

	typedef enum logic [2:0] {
		CLS_ZERO = 3'd0,
		CLS_SUB  = 3'd1,
		CLS_NORM = 3'd2,
		CLS_INF  = 3'd3,
		CLS_NAN  = 3'd4
	} value_class_t;

	typedef struct packed {
		logic        sign;
		logic [10:0] exponent_field;
		logic [51:0] mantissa_field;
	} in_req_t;

	typedef struct packed {
		logic [2:0]  value_class;
		logic [63:0] double_bits;
	} out_req_t;

endpackage

>>> hdl/minifloat_to_double_converter.sv
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | in_data  (sign, exponent_field, mantissa_field)
// out     | out_valid | out_ready | out_data (value_class, double_bits)
// cfg     | cfg_we    | -         | cfg_idx, cfg_wdata
// One request per cycle unless a stall at out backs up; the depth is the three
// compute stages (mask and classify, leading-one search, shift and pack) plus
// the output register. arst_n clears the valid bits and loads the width
// registers; data registers are not reset. A stall at out holds the output
// register; a stage behind it holds only while every later stage holds a
// request, and in_ready drops once all four stages are full and out is stalled.
module minifloat_to_double_converter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  m2d_pkg::in_req_t       in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output m2d_pkg::out_req_t      out_data,
	input  logic                   cfg_we,
	input  logic [5:0]             cfg_idx,
	input  logic [5:0]             cfg_wdata
);

	logic [3:0] exp_bits_q;
	logic [5:0] mant_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_bits_q  <= m2d_pkg::EXP_BITS_RESET;
			mant_bits_q <= m2d_pkg::MANT_BITS_RESET;
		end else if (cfg_we) begin
			if (cfg_idx == m2d_pkg::REG_EXP_BITS)  exp_bits_q  <= cfg_wdata[3:0];
			if (cfg_idx == m2d_pkg::REG_MANT_BITS) mant_bits_q <= cfg_wdata;
		end
	end

	logic [3:0] e_sat;
	logic [5:0] m_sat;
	always_comb begin
		e_sat = exp_bits_q;
		if (e_sat < 4'd2) e_sat = 4'd2;
		if (32'(e_sat) > m2d_pkg::MAX_EXP_BITS) e_sat = 4'(m2d_pkg::MAX_EXP_BITS);
		m_sat = mant_bits_q;
		if (m_sat < 6'd1) m_sat = 6'd1;
		if (32'(m_sat) > m2d_pkg::MAX_MANT_BITS) m_sat = 6'(m2d_pkg::MAX_MANT_BITS);
	end

	logic v1, v2, v3, v4;
	logic adv1, adv2, adv3, adv4;
	assign adv4 = !v4 || out_ready;
	assign adv3 = !v3 || adv4;
	assign adv2 = !v2 || adv3;
	assign adv1 = !v1 || adv2;
	assign in_ready = adv1;

	// stage 1: mask, classify, prealign
	logic [10:0] e_in;
	logic [51:0] m_in;
	logic [10:0] emax;
	always_comb begin
		emax = 11'((12'd1 << e_sat) - 12'd1);
		e_in = in_data.exponent_field & emax;
		m_in = in_data.mantissa_field & 52'((53'd1 << m_sat) - 53'd1);
	end

	logic        sgn_s1;
	logic [10:0] e_s1;
	logic [51:0] m_s1, mal_s1;
	logic [2:0]  cls_s1;
	logic        e11_s1;
	logic [11:0] bias_s1;
	logic [5:0]  mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1 <= 1'b0;
		else if (adv1) v1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			sgn_s1  <= in_data.sign;
			e_s1    <= e_in;
			m_s1    <= m_in;
			mal_s1  <= m_in << (6'd52 - m_sat);
			e11_s1  <= (e_sat == 4'd11);
			bias_s1 <= 12'((12'd1 << (e_sat - 4'd1)) - 12'd1);
			mb_s1   <= m_sat;
			if (e_in == '0 && m_in == '0)  cls_s1 <= m2d_pkg::CLS_ZERO;
			else if (e_in == emax)         cls_s1 <= (m_in == '0) ? m2d_pkg::CLS_INF
			                                                      : m2d_pkg::CLS_NAN;
			else if (e_in == '0)           cls_s1 <= m2d_pkg::CLS_SUB;
			else                           cls_s1 <= m2d_pkg::CLS_NORM;
		end
	end

	// stage 2: leading-one search
	logic [5:0] pos;
	m2d_lzc u_lzc (.vec(m_s1), .pos(pos));

	logic        sgn_s2, e11_s2;
	logic [10:0] e_s2;
	logic [51:0] m_s2, mal_s2;
	logic [2:0]  cls_s2;
	logic [11:0] bias_s2;
	logic [5:0]  mb_s2, p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2 <= 1'b0;
		else if (adv2) v2 <= v1;
	end
	always_ff @(posedge clk) begin
		if (adv2 && v1) begin
			sgn_s2 <= sgn_s1; e11_s2 <= e11_s1; e_s2 <= e_s1; m_s2 <= m_s1;
			mal_s2 <= mal_s1; cls_s2 <= cls_s1; bias_s2 <= bias_s1;
			mb_s2 <= mb_s1; p_s2 <= pos;
		end
	end

	// stage 3: shift and pack
	logic [63:0] bits;
	logic [51:0] frac;
	logic [11:0] de;
	always_comb begin
		frac = (m_s2 & 52'((53'd1 << p_s2) - 53'd1)) << (6'd52 - p_s2);
		de   = 12'(p_s2) + 12'd1 + m2d_pkg::DBL_BIAS - 12'(mb_s2) - bias_s2;
		case (cls_s2)
			m2d_pkg::CLS_ZERO: bits = {sgn_s2, 63'd0};
			m2d_pkg::CLS_INF:  bits = {sgn_s2, m2d_pkg::DBL_EMAX, 52'd0};
			m2d_pkg::CLS_NAN:  bits = m2d_pkg::DBL_QNAN;
			m2d_pkg::CLS_SUB:  bits = e11_s2 ? {sgn_s2, 11'd0, mal_s2}
			                                 : {sgn_s2, de[10:0], frac};
			default: begin
				de   = 12'(e_s2) + m2d_pkg::DBL_BIAS - bias_s2;
				bits = {sgn_s2, de[10:0], mal_s2};
			end
		endcase
	end

	m2d_pkg::out_req_t res_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3 <= 1'b0;
		else if (adv3) v3 <= v2;
	end
	always_ff @(posedge clk) begin
		if (adv3 && v2) begin
			res_s3.value_class <= cls_s2;
			res_s3.double_bits <= bits;
		end
	end

	m2d_pkg::out_req_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v4 <= 1'b0;
		else if (adv4) v4 <= v3;
	end
	always_ff @(posedge clk) begin
		if (adv4 && v3) out_q <= res_s3;
	end

	assign out_valid = v4;
	assign out_data  = out_q;

endmodule

>>> hdl/m2d_lzc.sv
module m2d_lzc (
	input  logic [51:0] vec,
	output logic [5:0]  pos
);

	logic [5:0] p16 [4];
	logic [3:0] nz;

	always_comb begin
		for (int g = 0; g < 4; g++) begin
			p16[g] = '0;
			nz[g]  = 1'b0;
			for (int i = 0; i < 13; i++) begin
				if (vec[g*13 + i]) begin
					p16[g] = 6'(g*13 + i);
					nz[g]  = 1'b1;
				end
			end
		end
		pos = '0;
		for (int g = 0; g < 4; g++) begin
			if (nz[g]) begin
				pos = p16[g];
			end
		end
	end

endmodule
